>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Store geometry
    localparam int DEPTH     = 64;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W      = 4;
    localparam int DATA_W    = 32;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 7;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_REAR  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_REAR   = 4'd3,
        OP_PEEK_FRONT = 4'd4,
        OP_PEEK_REAR  = 4'd5,
        OP_MAX        = 4'd6,
        OP_MIN        = 4'd7,
        OP_CLEAR      = 4'd8
    } t_op;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    // Circular index step toward the front
    function automatic t_idx slot_up(t_idx i);
        return (i == t_idx'(DEPTH - 1)) ? '0 : i + t_idx'(1);
    endfunction

    // Circular index step toward the rear
    function automatic t_idx slot_down(t_idx i);
        return (i == '0) ? t_idx'(DEPTH - 1) : i - t_idx'(1);
    endfunction

    // Low bits of the entry count as reported
    function automatic logic [CNT_OUT_W-1:0] cnt_field(t_cnt c);
        logic [CNT_W+CNT_OUT_W-1:0] ext;
        ext = {{CNT_OUT_W{1'b0}}, c};
        return ext[CNT_OUT_W-1:0];
    endfunction

endpackage

>>> src/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for queue requests and responses.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::OP_W-1:0]     operation;
    logic signed [deq_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [deq_pkg::ST_W-1:0]         status;
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic [deq_pkg::CNT_OUT_W-1:0]    count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);
endinterface

>>> src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of signed 32-bit values in a circular RAM store.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request item (operation, value); o_rsp returns one
//   result item (status, data, count) per request, in request order.
//   Push, clear and unknown codes: the result is registered at accept and
//   the next request can be taken in the following cycle, so these run at
//   one item per cycle while the receiver takes each result.
//   Pop and peek: result taken from the registered RAM read in S_READ.
//   Max and min: on an empty queue the result is registered at accept; the
//   scan reads one stored entry per cycle through the single RAM read port
//   and holds off new requests.
//   Reset clears the indices, the entry count and the output valid flag;
//   the store itself is not cleared, only live entries ever reach a result.
//   When the receiver stalls, the result waits in the output register and
//   no further request is taken until it drains (or drains in the same
//   cycle as the new request is accepted).
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    deq_req_if.sink     i_req,
    deq_rsp_if.source   o_rsp
);

    // Control state
    deq_pkg::t_state r_state, n_state;
    deq_pkg::t_idx   r_front, n_front;
    deq_pkg::t_idx   r_rear, n_rear;
    deq_pkg::t_cnt   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    // Scan state
    deq_pkg::t_idx   r_slot, n_slot;
    deq_pkg::t_cnt   r_left, n_left;
    deq_pkg::t_data  r_best, n_best;
    logic            r_first, n_first;
    logic            r_is_max, n_is_max;

    // Output payload
    logic [deq_pkg::ST_W-1:0]      r_status, n_status;
    deq_pkg::t_data                r_data, n_data;
    logic [deq_pkg::CNT_OUT_W-1:0] r_count, n_count;

    // RAM port
    logic                          ram_we;
    deq_pkg::t_idx                 ram_waddr;
    deq_pkg::t_idx                 ram_raddr;
    logic [deq_pkg::DATA_W-1:0]    ram_wdata;
    logic [deq_pkg::DATA_W-1:0]    ram_rdata;

    logic           req_fire;
    logic           out_free;
    deq_pkg::t_op   op;
    deq_pkg::t_data cand;
    logic           better;
    deq_pkg::t_cnt  cnt_dec;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == deq_pkg::S_IDLE) && out_free;
    assign req_fire  = i_req.valid && i_req.ready;
    assign op        = deq_pkg::t_op'(i_req.operation);
    assign cand      = deq_pkg::t_data'(ram_rdata);
    assign better    = r_is_max ? (cand > r_best) : (cand < r_best);
    assign cnt_dec   = r_cnt - deq_pkg::t_cnt'(1);

    // Result channel
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.data   = r_data;
    assign o_rsp.count  = r_count;

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_front     <= '0;
            r_rear      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_left   <= n_left;
        r_best   <= n_best;
        r_first  <= n_first;
        r_is_max <= n_is_max;
        r_status <= n_status;
        r_data   <= n_data;
        r_count  <= n_count;
    end

    // Sequencer: decode, index update, RAM access, result load
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_rear      = r_rear;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_slot      = r_slot;
        n_left      = r_left;
        n_best      = r_best;
        n_first     = r_first;
        n_is_max    = r_is_max;
        n_status    = r_status;
        n_data      = r_data;
        n_count     = r_count;
        ram_we      = 1'b0;
        ram_waddr   = r_front;
        ram_wdata   = i_req.value;
        ram_raddr   = r_slot;

        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (req_fire) begin
                    case (op) inside
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            if (r_cnt == deq_pkg::t_cnt'(deq_pkg::DEPTH)) begin
                                n_status = deq_pkg::ST_FULL;
                            end else begin
                                n_status = deq_pkg::ST_OK;
                                n_cnt    = r_cnt + deq_pkg::t_cnt'(1);
                                ram_we   = 1'b1;
                                if (op == deq_pkg::OP_PUSH_FRONT) begin
                                    if (r_cnt == '0) begin
                                        n_rear    = r_front;
                                        ram_waddr = r_front;
                                    end else begin
                                        n_front   = deq_pkg::slot_up(r_front);
                                        ram_waddr = deq_pkg::slot_up(r_front);
                                    end
                                end else begin
                                    if (r_cnt == '0) begin
                                        n_front   = r_rear;
                                        ram_waddr = r_rear;
                                    end else begin
                                        n_rear    = deq_pkg::slot_down(r_rear);
                                        ram_waddr = deq_pkg::slot_down(r_rear);
                                    end
                                end
                            end
                            n_count = deq_pkg::cnt_field(n_cnt);
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR,
                        deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_REAR: begin
                            ram_raddr = i_req.operation[0] ? r_rear : r_front;
                            if (r_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = deq_pkg::ST_EMPTY;
                                n_data      = '0;
                            end else begin
                                n_state = deq_pkg::S_READ;
                                if (op == deq_pkg::OP_POP_FRONT) begin
                                    n_cnt = cnt_dec;
                                    if (cnt_dec != '0) begin
                                        n_front = deq_pkg::slot_down(r_front);
                                    end
                                end else if (op == deq_pkg::OP_POP_REAR) begin
                                    n_cnt = cnt_dec;
                                    if (cnt_dec != '0) begin
                                        n_rear = deq_pkg::slot_up(r_rear);
                                    end
                                end
                            end
                            n_count = deq_pkg::cnt_field(n_cnt);
                        end
                        deq_pkg::OP_MAX, deq_pkg::OP_MIN: begin
                            ram_raddr = r_rear;
                            n_count   = deq_pkg::cnt_field(r_cnt);
                            if (r_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = deq_pkg::ST_EMPTY;
                                n_data      = '0;
                            end else begin
                                n_state  = deq_pkg::S_SCAN;
                                n_slot   = deq_pkg::slot_up(r_rear);
                                n_left   = r_cnt;
                                n_first  = 1'b1;
                                n_is_max = (op == deq_pkg::OP_MAX);
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            n_front     = '0;
                            n_rear      = '0;
                            n_cnt       = '0;
                            n_out_valid = 1'b1;
                            n_status    = deq_pkg::ST_OK;
                            n_data      = '0;
                            n_count     = '0;
                        end
                        default: begin
                            // unknown code: no change, plain ok result
                            n_out_valid = 1'b1;
                            n_status    = deq_pkg::ST_OK;
                            n_data      = '0;
                            n_count     = deq_pkg::cnt_field(r_cnt);
                        end
                    endcase
                end
            end
            deq_pkg::S_READ: begin
                // output register is empty here: it drained at accept
                n_out_valid = 1'b1;
                n_status    = deq_pkg::ST_OK;
                n_data      = cand;
                n_state     = deq_pkg::S_IDLE;
            end
            deq_pkg::S_SCAN: begin
                // absorb one entry per cycle, fetch the next
                ram_raddr = r_slot;
                n_best    = (r_first || better) ? cand : r_best;
                n_first   = 1'b0;
                if (r_left == deq_pkg::t_cnt'(1)) begin
                    n_out_valid = 1'b1;
                    n_status    = deq_pkg::ST_OK;
                    n_data      = (r_first || better) ? cand : r_best;
                    n_state     = deq_pkg::S_IDLE;
                end else begin
                    n_left = r_left - deq_pkg::t_cnt'(1);
                    n_slot = deq_pkg::slot_up(r_slot);
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= deq_pkg::t_cnt'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && !i_req.operation[3] && (i_req.operation[2:1] == 2'b00)
         && (r_cnt == deq_pkg::t_cnt'(deq_pkg::DEPTH)))
        |=> ($stable(r_cnt) && $stable(r_front) && $stable(r_rear)
             && (r_status == deq_pkg::ST_FULL)))
        else $error("push to full queue changed state");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_READ) |=> (r_out_valid && (r_status == deq_pkg::ST_OK)))
        else $error("pop or peek produced no result");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_SCAN) |-> ((r_left != '0) && (r_cnt != '0)))
        else $error("scan running with nothing left");

endmodule
